[hdl/btwl_pkg.sv]
// Shared types and constants for the blocked task wait list.
// No dependencies; imported by btwl_cell and blocked_task_wait_list.
package btwl_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int SEMAPHORES = 16;

  localparam int TASK_W  = 8;
  localparam int TIME_W  = 64;
  localparam int SEM_W   = 4;
  localparam int AVAIL_W = 16;

  // Semaphore ids at or above SEMAPHORES never count as available.
  localparam logic [AVAIL_W-1:0] SEM_MASK =
      (SEMAPHORES >= AVAIL_W) ? {AVAIL_W{1'b1}} : AVAIL_W'((17'd1 << SEMAPHORES) - 17'd1);

  // Item kind carried on the input tuser
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_UNBLOCK = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEL
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic               eval;
    logic               commit;
    logic               op;
    logic [TASK_W-1:0]  task_id;
    logic               wait_kind;
    logic [TIME_W-1:0]  wake_time;
    logic [SEM_W-1:0]   sem_id;
    logic [TIME_W-1:0]  now;
    logic [AVAIL_W-1:0] avail;
  } cell_cmd_t;

  // Priority chain passed from cell to cell
  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] task_id;
    logic              took;
    logic [SEM_W-1:0]  sem_id;
  } chain_t;

endpackage

[hdl/btwl_cell.sv]
// One wait list slot: stored task entry, ready/free flag and chain link.
// Depends on btwl_pkg.
module btwl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btwl_pkg::cell_cmd_t cmd_i,
  input  btwl_pkg::chain_t    chain_i,
  output btwl_pkg::chain_t    chain_o
);
  import btwl_pkg::*;

  logic              used_q;
  logic              kind_q;
  logic [TASK_W-1:0] task_q;
  logic [TIME_W-1:0] wake_q;
  logic [SEM_W-1:0]  sem_q;
  logic              hit_q, hit_d;
  logic              take_q, take_d;
  logic              sem_ok, due, grant;

  always_comb begin
    sem_ok = cmd_i.avail[sem_q];
    due    = (wake_q <= cmd_i.now);
    take_d = used_q & kind_q & sem_ok;
    if (cmd_i.op == OP_ADD) begin
      hit_d = ~used_q;
    end else begin
      hit_d = used_q & (due | (kind_q & sem_ok));
    end
  end

  // first flagged cell down the chain wins
  assign grant = hit_q & ~chain_i.found;

  always_comb begin
    chain_o.found   = chain_i.found | hit_q;
    chain_o.task_id = chain_i.task_id | (grant ? task_q : '0);
    chain_o.took    = chain_i.took | (grant & take_q);
    chain_o.sem_id  = chain_i.sem_id | ((grant & take_q) ? sem_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      hit_q  <= 1'b0;
      take_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        hit_q  <= hit_d;
        take_q <= take_d;
      end
      if (cmd_i.commit && grant) begin
        used_q <= (cmd_i.op == OP_ADD);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && grant && (cmd_i.op == OP_ADD)) begin
      task_q <= cmd_i.task_id;
      kind_q <= cmd_i.wait_kind;
      wake_q <= cmd_i.wake_time;
      sem_q  <= cmd_i.sem_id;
    end
  end

endmodule

[hdl/blocked_task_wait_list.sv]
// Blocked task wait list: a row of SLOTS cells with a lowest-slot-first grant chain.
// One item at a time: the input is not ready again until the item has committed.
// On input transfer each cell registers its free/ready flag (64-bit time compare);
// then the grant ripples across cells and commits to the output register once free.
// Reset: asynchronous, active low; empties every slot and the output register.
// Depends on btwl_pkg and btwl_cell.
module blocked_task_wait_list #(
  parameter int SLOTS = btwl_pkg::SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] task_id, [8] wait_kind, [72:9] wake_time, [76:73] semaphore_id,
  // [140:77] now, [156:141] sem_available, [159:157] zero
  input  logic [159:0] s_axis_tdata_i,
  // [0] op (0 add, 1 unblock)
  input  logic         s_axis_tuser_i,
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] released, [8:1] released_task, [9] took_semaphore,
  // [13:10] taken_semaphore, [14] add_refused, [15] zero
  output logic [15:0]  m_axis_tdata_o
);
  import btwl_pkg::*;

  state_e state_q, state_d;

  // item fields held for the commit cycle
  logic              op_q;
  logic [TASK_W-1:0] task_q;
  logic              kind_q;
  logic [TIME_W-1:0] wake_q;
  logic [SEM_W-1:0]  sem_q;

  logic        m_valid_q, m_valid_d;
  logic [15:0] m_data_q, m_data_d;

  logic      s_xfer, commit;
  cell_cmd_t cmd;
  chain_t    chain [SLOTS+1];
  chain_t    tail;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;
  // commit only when the output register is free or draining this cycle
  assign commit          = (state_q == ST_SEL) & (~m_valid_q | m_axis_tready_i);

  always_comb begin
    cmd.eval      = s_xfer;
    cmd.commit    = commit;
    cmd.op        = (state_q == ST_IDLE) ? s_axis_tuser_i : op_q;
    cmd.task_id   = task_q;
    cmd.wait_kind = kind_q;
    cmd.wake_time = wake_q;
    cmd.sem_id    = sem_q;
    cmd.now       = s_axis_tdata_i[140:77];
    cmd.avail     = s_axis_tdata_i[156:141] & SEM_MASK;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    btwl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  assign tail = chain[SLOTS];

  // controller
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result assembly and output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready_i) m_valid_d = 1'b0;
    if (commit) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      if (op_q == OP_ADD) begin
        m_data_d[14] = ~tail.found;
      end else if (tail.found) begin
        m_data_d[0]     = 1'b1;
        m_data_d[8:1]   = tail.task_id;
        m_data_d[9]     = tail.took;
        m_data_d[13:10] = tail.sem_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (s_xfer) begin
      op_q   <= s_axis_tuser_i;
      task_q <= s_axis_tdata_i[7:0];
      kind_q <= s_axis_tdata_i[8];
      wake_q <= s_axis_tdata_i[72:9];
      sem_q  <= s_axis_tdata_i[76:73];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // one item in flight: no new transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // a new result only appears out of the commit cycle
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_SEL))
    else $error("result appeared without a commit");

  // a result is never both a release and a refused add
  a_release_xor_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[0] && m_data_q[14]))
    else $error("release and refusal in the same result");

  // a taken semaphore implies a released task
  a_took_needs_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[9]) |-> m_data_q[0])
    else $error("semaphore taken without a release");

endmodule
